// ===== src/slc_pkg.sv =====
// Shared types, constants and helpers for the screen line clipper.
`default_nettype none
package slc_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int CW = 24;            // coordinate width
  localparam int VW = 16;            // viewport register width
  localparam int DW = CW + 1;        // difference / divisor width
  localparam int PW = 2 * DW;        // product width
  localparam int QW = 26;            // quotient bits kept; larger saturates
  localparam int SW = QW + 2;        // width of the moved-coordinate sum
  localparam int CLIP_PASSES = 8;

  localparam logic [3:0] OC_LEFT   = 4'h1;
  localparam logic [3:0] OC_RIGHT  = 4'h2;
  localparam logic [3:0] OC_BOTTOM = 4'h4;
  localparam logic [3:0] OC_TOP    = 4'h8;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  localparam logic signed [CW-1:0] C24_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C24_MIN = {1'b1, {(CW-1){1'b0}}};

  // One item moving down the divider row.
  typedef struct packed {
    logic          vld;
    logic [DW-1:0] rem;
    logic [QW-1:0] num;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
  } div_item_t;

  function automatic logic [3:0] outcode(
    input logic signed [CW-1:0] x,
    input logic signed [CW-1:0] y,
    input logic signed [CW-1:0] xmin,
    input logic signed [CW-1:0] xmax,
    input logic signed [CW-1:0] ymin,
    input logic signed [CW-1:0] ymax
  );
    logic [3:0] c;
    c = 4'h0;
    if (x < xmin) c = c | OC_LEFT;
    if (x > xmax) c = c | OC_RIGHT;
    if (y < ymin) c = c | OC_TOP;
    if (y > ymax) c = c | OC_BOTTOM;
    return c;
  endfunction

  function automatic logic signed [CW-1:0] sat24(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'(C24_MAX);
    lo = SW'(C24_MIN);
    if (v > hi) return C24_MAX;
    if (v < lo) return C24_MIN;
    return v[CW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/slc_div_cell.sv =====
// One restoring-division step: shift in a numerator bit, trial subtract, emit a quotient bit.
`default_nettype none
module slc_div_cell
  import slc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire div_item_t din,
  output div_item_t      dout
);

  logic [DW:0] trial;
  logic        ge;

  always_comb begin
    trial = {din.rem, din.num[QW-1]};
    ge    = trial >= {1'b0, din.den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.rem <= ge ? DW'(trial - {1'b0, din.den}) : trial[DW-1:0];
    dout.num <= {din.num[QW-2:0], 1'b0};
    dout.den <= din.den;
    dout.quo <= {din.quo[QW-2:0], ge};
  end

endmodule
`default_nettype wire

// ===== src/slc_div_chain.sv =====
// Row of division cells, one quotient bit per cell, handed on every cycle.
`default_nettype none
module slc_div_chain
  import slc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire div_item_t din,
  output div_item_t      dout
);

  div_item_t link [QW+1];

  assign link[0] = din;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    slc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dout = link[QW];

endmodule
`default_nettype wire

// ===== src/screen_line_clip_2d_top.sv =====
// Top level of the screen line clipper: pass sequencer, multiplier and divider row.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: segment endpoints
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: clipped endpoints, m_tuser: flags
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data: viewport edge
//
// Each clip move with a nonzero divisor, at most 8 per segment, runs one pass through the
// 26-cell divider row after the multiply and operand-preparation states. Moves on vertical
// or horizontal lines skip the multiplier and divider and update the point directly.
// Reset returns the viewport to 0,0..639,479 and empties the output register.
// A new segment is taken while the previous result waits; a result is held until
// m_tready, and the sequencer waits in its final state while the output is full.
`default_nettype none
module screen_line_clip_2d_top
  import slc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // first_x, first_y, second_x, second_y
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // out_first_x, out_first_y, out_second_x, out_second_y
  output logic [1:0]       m_tuser,   // accepted, swapped
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;

  logic signed [VW-1:0] view_x_min, view_y_min, view_x_max, view_y_max;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] dx, dy;
  logic                 swp, acc, xclip, ovf, negq;
  logic [3:0]           pass;
  logic signed [CW-1:0] edge_v;
  logic signed [DW-1:0] num, mul, den;
  logic signed [PW-1:0] prod;

  // Edges in fixed point; they fit the coordinate width at 8 fraction bits.
  logic signed [CW-1:0] xmin_e, xmax_e, ymin_e, ymax_e;
  assign xmin_e = {view_x_min, {COORD_FRAC_BITS{1'b0}}};
  assign xmax_e = {view_x_max, {COORD_FRAC_BITS{1'b0}}};
  assign ymin_e = {view_y_min, {COORD_FRAC_BITS{1'b0}}};
  assign ymax_e = {view_y_max, {COORD_FRAC_BITS{1'b0}}};

  logic [3:0]           c0, c1, cc;
  logic                 do_swap, is_x;
  logic signed [CW-1:0] pax, pay, pbx, pby, e_sel;
  logic signed [DW-1:0] num_c, mul_c, den_c;

  always_comb begin
    c0      = outcode(ax, ay, xmin_e, xmax_e, ymin_e, ymax_e);
    c1      = outcode(bx, by, xmin_e, xmax_e, ymin_e, ymax_e);
    do_swap = (c0 == 4'h0);
    cc      = do_swap ? c1 : c0;
    pax     = do_swap ? bx : ax;
    pay     = do_swap ? by : ay;
    pbx     = do_swap ? ax : bx;
    pby     = do_swap ? ay : by;
    is_x    = |(cc & (OC_LEFT | OC_RIGHT));
    if (is_x) begin
      e_sel = |(cc & OC_LEFT) ? xmin_e : xmax_e;
      num_c = {e_sel[CW-1], e_sel} - {pax[CW-1], pax};
      mul_c = dy;
      den_c = dx;
    end else begin
      e_sel = |(cc & OC_BOTTOM) ? ymax_e : ymin_e;
      num_c = {e_sel[CW-1], e_sel} - {pay[CW-1], pay};
      mul_c = dx;
      den_c = dy;
    end
  end

  // Divider operands: magnitudes, with half the divisor added for rounding.
  logic [PW-1:0] up, nrm;
  logic [DW-1:0] ud;
  always_comb begin
    up  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    ud  = den[DW-1] ? DW'(-den) : DW'(den);
    nrm = up + {{DW{1'b0}}, ud >> 1};
  end

  div_item_t chain_in, chain_out;
  always_comb begin
    chain_in.vld = (state == ST_PREP);
    chain_in.rem = {1'b0, nrm[PW-1:QW]};
    chain_in.num = nrm[QW-1:0];
    chain_in.den = ud;
    chain_in.quo = '0;
  end

  slc_div_chain u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (chain_in),
    .dout (chain_out)
  );

  // Move the dependent coordinate by the rounded, clamped quotient.
  logic [QW-1:0]        qm;
  logic signed [SW-1:0] qs, msum;
  logic signed [CW-1:0] base, moved;
  always_comb begin
    qm    = ovf ? {QW{1'b1}} : chain_out.quo;
    qs    = negq ? SW'(-$signed({2'b00, qm})) : $signed({2'b00, qm});
    base  = xclip ? ay : ax;
    msum  = {{(SW-CW){base[CW-1]}}, base} + qs;
    moved = sat24(msum);
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x_min <= 16'sd0;
      view_y_min <= 16'sd0;
      view_x_max <= 16'sd639;
      view_y_max <= 16'sd479;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_MIN: view_x_min <= cfg_data;
        REG_Y_MIN: view_y_min <= cfg_data;
        REG_X_MAX: view_x_max <= cfg_data;
        REG_Y_MAX: view_y_max <= cfg_data;
        default:   view_x_min <= view_x_min;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads in the same cycle
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ax    <= s_tdata[23:0];
            ay    <= s_tdata[47:24];
            bx    <= s_tdata[71:48];
            by    <= s_tdata[95:72];
            dx    <= {s_tdata[71], s_tdata[71:48]} - {s_tdata[23], s_tdata[23:0]};
            dy    <= {s_tdata[95], s_tdata[95:72]} - {s_tdata[47], s_tdata[47:24]};
            swp   <= 1'b0;
            acc   <= 1'b0;
            pass  <= 4'd0;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if ((c0 | c1) == 4'h0) begin
            acc   <= 1'b1;
            state <= ST_DONE;
          end else if ((c0 & c1) != 4'h0 || pass == 4'(CLIP_PASSES)) begin
            state <= ST_DONE;
          end else begin
            bx     <= pbx;
            by     <= pby;
            swp    <= swp ^ do_swap;
            xclip  <= is_x;
            edge_v <= e_sel;
            num    <= num_c;
            mul    <= mul_c;
            den    <= den_c;
            if (den_c == '0) begin
              // straight line: only the clipped coordinate moves
              ax   <= is_x ? e_sel : pax;
              ay   <= is_x ? pay : e_sel;
              pass <= pass + 4'd1;
            end else begin
              ax    <= pax;
              ay    <= pay;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod  <= num * mul;
          state <= ST_PREP;
        end
        ST_PREP: begin
          ovf   <= {1'b0, nrm[PW-1:QW]} >= ud;
          negq  <= prod[PW-1] ^ den[DW-1];
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (chain_out.vld) begin
            if (xclip) begin
              ay <= moved;
              ax <= edge_v;
            end else begin
              ax <= moved;
              ay <= edge_v;
            end
            pass  <= pass + 4'd1;
            state <= ST_EVAL;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {by, bx, ay, ax};
            m_tuser  <= {swp, acc};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
